>>> design/sorted_timer_queue_top_assert.svh
// assertion macros for the timer queue
`ifndef SORTED_TIMER_QUEUE_TOP_ASSERT_SVH
`define SORTED_TIMER_QUEUE_TOP_ASSERT_SVH

// a condition that must hold at every edge out of reset
`define STQ_ASSERT_ALWAYS(lbl, clk, rst_n, cond, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (cond)) else $error(msg);

// an antecedent that implies a consequent in the next cycle
`define STQ_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`endif

>>> design/stq_pkg.sv
package stq_pkg;

	localparam int NumTimers = 32;
	localparam int IdW = 6;
	localparam int MaxResults = 32;
	localparam logic [31:0] EndDue = 32'hffff_ffff;
	localparam logic [31:0] MaxDue = 32'hffff_fffe;
	localparam int CmdDepth = 4;

	typedef enum logic [2:0] {
		OP_ALLOC = 3'd0,
		OP_FREE = 3'd1,
		OP_SET = 3'd2,
		OP_ARM = 3'd3,
		OP_TICK = 3'd4
	} op_t;

	typedef enum logic [1:0] {
		KIND_ACK = 2'd0,
		KIND_EXPIRED = 2'd1,
		KIND_DONE = 2'd2
	} kind_t;

	typedef enum logic [1:0] {
		STAT_OK = 2'd0,
		STAT_NO_SLOT = 2'd1,
		STAT_BAD_STATE = 2'd2
	} status_t;

	typedef enum logic [1:0] {
		SLOT_FREE = 2'd0,
		SLOT_ALLOC = 2'd1,
		SLOT_RUN = 2'd2
	} slot_state_t;

	typedef struct packed {
		logic [2:0] op;
		logic [5:0] timer_id;
		logic [3:0] dest_queue;
		logic signed [31:0] payload;
		logic [31:0] delay;
	} in_item_t;

	typedef struct packed {
		logic [1:0] kind;
		logic [1:0] status;
		logic [5:0] slot;
		logic [3:0] out_queue;
		logic signed [31:0] out_payload;
		logic switch_task;
		logic last;
	} out_item_t;

	// command from the front end to the back end
	typedef struct packed {
		op_t op;
		logic [5:0] timer_id;
		logic [3:0] dest_queue;
		logic [31:0] payload;
		logic [31:0] delay;
	} cmd_t;

	typedef enum logic [2:0] {
		BE_IDLE,
		BE_ARM_WALK,
		BE_TICK_WALK,
		BE_TICK_EMIT,
		BE_TICK_DONE
	} be_state_t;

	// back end status toward the front end
	typedef struct packed {
		logic busy;
		logic fifo_empty;
	} be_stat_t;

endpackage

>>> design/sorted_timer_queue_top.sv
// allocate, free and set: the back end registers the answer as it takes the request
// arm walks the sorted list, one entry a cycle
// tick: each expired timer but the switch timer gives a result; one request in the back end at a time
// the command queue holds up to 4 requests so the front keeps taking them
// reset (arst_n low, async): empty list with only the end marker, count zero
`include "sorted_timer_queue_top_assert.svh"
module sorted_timer_queue_top (
	input  logic                 clk,
	input  logic                 arst_n,
	input  stq_pkg::in_item_t    in_item,
	input  logic                 push,
	output logic                 full,
	output stq_pkg::out_item_t   out_item,
	output logic                 empty,
	input  logic                 pop,
	input  logic [5:0]           cfg_data,
	input  logic                 cfg_valid,
	output logic                 cfg_ready
);

	// switch timer register
	logic [5:0] switch_id_q;

	// front to back command path
	stq_pkg::cmd_t cmd;
	logic cmd_valid, cmd_take;
	logic res_valid;
	stq_pkg::be_stat_t be_stat;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			switch_id_q <= '0;
		end else if (cfg_valid && cfg_ready) begin
			switch_id_q <= cfg_data;
		end
	end

	// front: takes requests, drops unknown codes, queues the rest
	stq_front u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_item  (in_item),
		.push     (push),
		.full     (full),
		.cmd      (cmd),
		.cmd_valid(cmd_valid),
		.cmd_take (cmd_take)
	);

	// back: holds the timer list and the single result register
	stq_back u_back (
		.clk            (clk),
		.arst_n         (arst_n),
		.switch_timer_id(switch_id_q),
		.cmd            (cmd),
		.cmd_valid      (cmd_valid),
		.cmd_take       (cmd_take),
		.res            (out_item),
		.res_valid      (res_valid),
		.res_ready      (pop),
		.stat           (be_stat)
	);

	assign empty = !res_valid;

	// a command is only taken by an idle back end with an empty result slot
	`STQ_ASSERT_ALWAYS(a_take_idle, clk, arst_n, !cmd_take || (!be_stat.busy && res_valid == 1'b0 && !be_stat.fifo_empty), "command taken while busy")
	// a result taken by an idle back end leaves the output empty
	`STQ_ASSERT_NEXT(a_pop_clears, clk, arst_n, pop && !empty && !be_stat.busy, empty, "result kept after pop")
	// a tick done result always ends its request
	`STQ_ASSERT_ALWAYS(a_done_last, clk, arst_n, empty || out_item.kind != stq_pkg::KIND_DONE || out_item.last, "done without last")

endmodule

>>> design/stq_front.sv
module stq_front (
	input  logic                clk,
	input  logic                arst_n,
	input  stq_pkg::in_item_t   in_item,
	input  logic                push,
	output logic                full,
	output stq_pkg::cmd_t       cmd,
	output logic                cmd_valid,
	input  logic                cmd_take
);

	localparam int AW = $clog2(stq_pkg::CmdDepth);

	stq_pkg::cmd_t mem_q [stq_pkg::CmdDepth];
	logic [AW-1:0] wr_q, rd_q;
	logic [AW:0] cnt_q;
	logic known;

	// unknown codes are dropped here and never queued
	always_comb begin
		known = (in_item.op == stq_pkg::OP_ALLOC) || (in_item.op == stq_pkg::OP_FREE) ||
			(in_item.op == stq_pkg::OP_SET) || (in_item.op == stq_pkg::OP_ARM) ||
			(in_item.op == stq_pkg::OP_TICK);
	end

	assign full = (cnt_q == (AW+1)'(stq_pkg::CmdDepth));
	assign cmd_valid = (cnt_q != '0);
	assign cmd = mem_q[rd_q];

	always_ff @(posedge clk) begin
		if (push && !full && known) begin
			mem_q[wr_q] <= '{op: stq_pkg::op_t'(in_item.op), timer_id: in_item.timer_id,
				dest_queue: in_item.dest_queue, payload: in_item.payload,
				delay: in_item.delay};
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q <= '0;
			rd_q <= '0;
			cnt_q <= '0;
		end else begin
			if (push && !full && known) wr_q <= wr_q + 1'b1;
			if (cmd_take) rd_q <= rd_q + 1'b1;
			cnt_q <= cnt_q + (AW+1)'(push && !full && known) - (AW+1)'(cmd_take);
		end
	end

endmodule

>>> design/stq_back.sv
module stq_back (
	input  logic              clk,
	input  logic              arst_n,
	input  logic [5:0]        switch_timer_id,
	input  stq_pkg::cmd_t     cmd,
	input  logic              cmd_valid,
	output logic              cmd_take,
	output stq_pkg::out_item_t res,
	output logic              res_valid,
	input  logic              res_ready,
	output stq_pkg::be_stat_t stat
);

	localparam int N = stq_pkg::NumTimers;
	localparam int SW = $clog2(N);
	localparam int CW = $clog2(stq_pkg::MaxResults + 1);

	stq_pkg::be_state_t state_q, state_d;
	stq_pkg::slot_state_t st_q [N];
	logic [31:0] due_q [N];
	logic [5:0] link_q [N];
	logic [3:0] queue_q [N];
	logic [31:0] pay_q [N];
	logic [31:0] tick_q;
	logic [31:0] next_due_q;
	logic [5:0] head_q;
	logic [5:0] cur_q, prev_q;
	logic prev_v_q;
	logic [31:0] arm_due_q;
	logic [5:0] arm_id_q;
	logic [CW-1:0] k_q;
	logic sw_q;
	logic [SW:0] n_q;

	logic [SW-1:0] cur_i, id_i;
	logic cur_in;
	logic in_range;
	logic [SW-1:0] free_idx;
	logic free_found;
	logic [32:0] sum;
	logic [31:0] due_calc;
	logic take;
	stq_pkg::out_item_t ack;
	logic ack_now;

	assign cur_i = cur_q[SW-1:0];
	assign cur_in = (cur_q < 6'(N));
	assign id_i = cmd.timer_id[SW-1:0];
	assign in_range = (cmd.timer_id < 6'(N));
	assign stat.busy = (state_q != stq_pkg::BE_IDLE);
	assign stat.fifo_empty = !cmd_valid;

	always_comb begin
		free_found = 1'b0;
		free_idx = '0;
		for (int i = N - 1; i >= 0; i--) begin
			if (st_q[i] == stq_pkg::SLOT_FREE) begin
				free_found = 1'b1;
				free_idx = SW'(i);
			end
		end
	end

	assign sum = {1'b0, tick_q} + {1'b0, cmd.delay};
	assign due_calc = (sum[32] || sum[31:0] > stq_pkg::MaxDue) ? stq_pkg::MaxDue : sum[31:0];

	// ack for single-step commands, issued straight from idle
	always_comb begin
		ack = '0;
		ack.kind = stq_pkg::KIND_ACK;
		ack.last = 1'b1;
		ack.slot = cmd.timer_id;
		ack_now = 1'b0;
		case (cmd.op)
			stq_pkg::OP_ALLOC: begin
				ack_now = 1'b1;
				ack.slot = free_found ? 6'(free_idx) : 6'd0;
				ack.status = free_found ? stq_pkg::STAT_OK : stq_pkg::STAT_NO_SLOT;
			end
			stq_pkg::OP_FREE: begin
				ack_now = 1'b1;
				ack.status = (in_range && st_q[id_i] == stq_pkg::SLOT_ALLOC) ?
					stq_pkg::STAT_OK : stq_pkg::STAT_BAD_STATE;
			end
			stq_pkg::OP_SET: begin
				ack_now = 1'b1;
				ack.status = (in_range && st_q[id_i] != stq_pkg::SLOT_FREE) ?
					stq_pkg::STAT_OK : stq_pkg::STAT_BAD_STATE;
			end
			stq_pkg::OP_ARM: begin
				ack_now = !(in_range && st_q[id_i] == stq_pkg::SLOT_ALLOC);
				ack.status = stq_pkg::STAT_BAD_STATE;
			end
			default: ack_now = 1'b0;
		endcase
	end

	logic [31:0] tick_next;
	assign tick_next = (tick_q < stq_pkg::MaxDue) ? tick_q + 32'd1 : tick_q;

	logic walk_stop_arm;
	assign walk_stop_arm = !cur_in || (n_q == (SW+1)'(N)) || (arm_due_q <= due_q[cur_i]);

	logic walk_stop_tick, cur_is_sw;
	assign cur_is_sw = (cur_q == switch_timer_id);
	assign walk_stop_tick = !cur_in || (n_q == (SW+1)'(N)) || (due_q[cur_i] > tick_q) ||
		(!cur_is_sw && k_q >= CW'(stq_pkg::MaxResults - 1));

	always_comb begin
		state_d = state_q;
		take = 1'b0;
		case (state_q)
			stq_pkg::BE_IDLE: begin
				if (cmd_valid && !res_valid) begin
					take = 1'b1;
					if (cmd.op == stq_pkg::OP_ARM && !ack_now) state_d = stq_pkg::BE_ARM_WALK;
					else if (cmd.op == stq_pkg::OP_TICK) state_d = stq_pkg::BE_TICK_WALK;
				end
			end
			stq_pkg::BE_ARM_WALK: if (walk_stop_arm && !res_valid) state_d = stq_pkg::BE_IDLE;
			stq_pkg::BE_TICK_WALK: begin
				if (next_due_q > tick_q || walk_stop_tick) state_d = stq_pkg::BE_TICK_DONE;
				else if (!cur_is_sw) state_d = stq_pkg::BE_TICK_EMIT;
			end
			stq_pkg::BE_TICK_EMIT: if (!res_valid) state_d = stq_pkg::BE_TICK_WALK;
			stq_pkg::BE_TICK_DONE: if (!res_valid) state_d = stq_pkg::BE_IDLE;
			default: state_d = stq_pkg::BE_IDLE;
		endcase
	end

	assign cmd_take = take;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= stq_pkg::BE_IDLE;
			res_valid <= 1'b0;
			tick_q <= '0;
			next_due_q <= stq_pkg::EndDue;
			head_q <= '0;
			for (int i = 0; i < N; i++) st_q[i] <= stq_pkg::SLOT_FREE;
			st_q[0] <= stq_pkg::SLOT_RUN;
			due_q[0] <= stq_pkg::EndDue;
			k_q <= '0;
			sw_q <= 1'b0;
			n_q <= '0;
		end else begin
			state_q <= state_d;
			if (res_valid && res_ready) res_valid <= 1'b0;
			case (state_q)
				stq_pkg::BE_IDLE: if (take) begin
					n_q <= '0;
					cur_q <= head_q;
					prev_v_q <= 1'b0;
					arm_id_q <= cmd.timer_id;
					arm_due_q <= due_calc;
					if (ack_now) begin
						res <= ack;
						res_valid <= 1'b1;
					end
					case (cmd.op)
						stq_pkg::OP_ALLOC: if (free_found) st_q[free_idx] <= stq_pkg::SLOT_ALLOC;
						stq_pkg::OP_FREE: if (ack.status == stq_pkg::STAT_OK)
							st_q[id_i] <= stq_pkg::SLOT_FREE;
						stq_pkg::OP_SET: if (ack.status == stq_pkg::STAT_OK) begin
							queue_q[id_i] <= cmd.dest_queue;
							pay_q[id_i] <= cmd.payload;
						end
						stq_pkg::OP_ARM: if (!ack_now) begin
							due_q[id_i] <= due_calc;
							st_q[id_i] <= stq_pkg::SLOT_RUN;
						end
						stq_pkg::OP_TICK: begin
							tick_q <= tick_next;
							k_q <= '0;
							sw_q <= 1'b0;
						end
						default: ;
					endcase
				end
				stq_pkg::BE_ARM_WALK: begin
					if (walk_stop_arm) begin
						if (!res_valid) begin
							link_q[arm_id_q[SW-1:0]] <= cur_in ? cur_q : 6'd0;
							if (!prev_v_q) begin
								head_q <= arm_id_q;
								next_due_q <= arm_due_q;
							end else begin
								link_q[prev_q[SW-1:0]] <= arm_id_q;
							end
							res <= '{kind: stq_pkg::KIND_ACK, status: stq_pkg::STAT_OK,
								slot: arm_id_q, out_queue: 4'd0, out_payload: 32'sd0,
								switch_task: 1'b0, last: 1'b1};
							res_valid <= 1'b1;
						end
					end else begin
						prev_q <= cur_q;
						prev_v_q <= 1'b1;
						cur_q <= link_q[cur_i];
						n_q <= n_q + 1'b1;
					end
				end
				stq_pkg::BE_TICK_WALK: begin
					if (next_due_q > tick_q) begin
						// nothing due: list untouched
					end else if (walk_stop_tick) begin
						head_q <= cur_in ? cur_q : 6'd0;
						next_due_q <= cur_in ? due_q[cur_i] : due_q[0];
					end else begin
						st_q[cur_i] <= stq_pkg::SLOT_ALLOC;
						if (cur_is_sw) begin
							sw_q <= 1'b1;
							cur_q <= link_q[cur_i];
							n_q <= n_q + 1'b1;
						end
					end
				end
				stq_pkg::BE_TICK_EMIT: if (!res_valid) begin
					res <= '{kind: stq_pkg::KIND_EXPIRED, status: stq_pkg::STAT_OK,
						slot: cur_q, out_queue: queue_q[cur_i], out_payload: pay_q[cur_i],
						switch_task: 1'b0, last: 1'b0};
					res_valid <= 1'b1;
					k_q <= k_q + 1'b1;
					cur_q <= link_q[cur_i];
					n_q <= n_q + 1'b1;
				end
				stq_pkg::BE_TICK_DONE: if (!res_valid) begin
					res <= '{kind: stq_pkg::KIND_DONE, status: stq_pkg::STAT_OK, slot: 6'd0,
						out_queue: 4'd0, out_payload: 32'sd0, switch_task: sw_q, last: 1'b1};
					res_valid <= 1'b1;
				end
				default: ;
			endcase
		end
	end

endmodule
